// ----- sv/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg
// Operator codes, status codes and character tables for the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

	typedef logic [7:0] char_t;
	typedef logic [2:0] op_code_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] prec_t;

	localparam op_code_t OP_NONE = 3'd0;
	localparam op_code_t OP_ADD  = 3'd1;
	localparam op_code_t OP_SUB  = 3'd2;
	localparam op_code_t OP_MUL  = 3'd3;
	localparam op_code_t OP_DIV  = 3'd4;
	localparam op_code_t OP_POW  = 3'd5;
	localparam op_code_t OP_LPAR = 3'd6;
	localparam op_code_t OP_RPAR = 3'd7;

	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_OVF = 2'd1;
	localparam status_t ST_UNM = 2'd2;

	localparam int RES_W = 6;
	localparam logic [RES_W-1:0] MAX_RESULTS = 6'd32;

	function automatic op_code_t code_of(input char_t c);
		op_code_t r;
		case (c)
			8'h2B:   r = OP_ADD;
			8'h2D:   r = OP_SUB;
			8'h2A:   r = OP_MUL;
			8'h2F:   r = OP_DIV;
			8'h5E:   r = OP_POW;
			8'h28:   r = OP_LPAR;
			8'h29:   r = OP_RPAR;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic char_t op_char(input op_code_t t);
		char_t r;
		case (t)
			OP_ADD:  r = 8'h2B;
			OP_SUB:  r = 8'h2D;
			OP_MUL:  r = 8'h2A;
			OP_DIV:  r = 8'h2F;
			OP_POW:  r = 8'h5E;
			OP_LPAR: r = 8'h28;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic prec_t op_prec(input op_code_t t);
		prec_t r;
		case (t)
			OP_ADD, OP_SUB: r = 2'd1;
			OP_MUL, OP_DIV: r = 2'd2;
			OP_POW:         r = 2'd3;
			default:        r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/itp_ram.sv -----
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/infix_to_postfix_converter.sv -----
// An operand is registered into the output on acceptance; '(' is pushed, or gives an
// overflow item on a full stack. An operator, ')' or end marker runs S_READ, S_EVAL
// per stack entry, then S_FIN. Throughput: 1 item per cycle for operands and '(' while
// the output is free; otherwise busy for the whole stack walk, paced by the registered stack RAM read.
// Reset: stack count, sequencer and output valid clear; stack contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: one infix character in, postfix characters out,
// with a bounded operator stack walked by a small sequencer.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  itp_pkg::char_t   in_char,
	input  logic             end_of_expr,
	output logic             out_valid,
	input  logic             out_stall,
	output itp_pkg::char_t   out_char,
	output logic             char_valid,
	output logic             last_of_run,
	output itp_pkg::status_t status
);

	import itp_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EVAL = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	localparam logic [1:0] M_END = 2'd0;
	localparam logic [1:0] M_RPAR = 2'd1;
	localparam logic [1:0] M_OP = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [1:0]       mode_q, mode_d;
	op_code_t         code_q, code_d;
	status_t          fin_st_q, fin_st_d;
	logic [CW-1:0]    count_q, count_d;
	logic [RES_W-1:0] nres_q, nres_d;
	logic             pend_valid_q, pend_valid_d;
	char_t            pend_char_q, pend_char_d;

	logic             out_valid_q;
	char_t            out_char_q, out_char_d;
	logic             out_cv_q, out_cv_d;
	logic             out_last_q, out_last_d;
	status_t          out_st_q, out_st_d;
	logic             out_load;
	logic             out_free;

	logic             ram_we;
	op_code_t         top;
	logic [CW-1:0]    rd_idx;
	op_code_t         in_code;
	logic             emit_ok;
	logic             pop_cond;
	logic             full;
	logic             in_acc;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;
	assign in_code  = code_of(in_char);
	assign rd_idx   = count_q - CW'(1);
	assign full     = (count_q >= DEPTH_C);
	assign emit_ok  = (nres_q >= MAX_RESULTS) || !pend_valid_q || out_free;
	assign pop_cond = (count_q != '0) && (top != OP_LPAR) && (top != OP_NONE)
		&& (top != OP_RPAR)
		&& ((op_prec(top) > op_prec(code_q))
		|| ((op_prec(top) == op_prec(code_q)) && (code_q != OP_POW)));

	itp_ram #(
		.WIDTH (3),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (ram_we && (state_q == S_IDLE) ? OP_LPAR : code_q),
		.raddr (rd_idx[AW-1:0]),
		.rdata (top)
	);

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		code_d       = code_q;
		fin_st_d     = fin_st_q;
		count_d      = count_q;
		nres_d       = nres_q;
		pend_valid_d = pend_valid_q;
		pend_char_d  = pend_char_q;
		out_load     = 1'b0;
		out_char_d   = '0;
		out_cv_d     = 1'b0;
		out_last_d   = 1'b0;
		out_st_d     = ST_OK;
		ram_we       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					nres_d       = '0;
					pend_valid_d = 1'b0;
					fin_st_d     = ST_OK;
					code_d       = in_code;
					if (end_of_expr) begin
						mode_d  = M_END;
						state_d = S_READ;
					end else if (in_code == OP_NONE) begin
						out_load   = 1'b1;
						out_char_d = in_char;
						out_cv_d   = 1'b1;
						out_last_d = 1'b1;
					end else if (in_code == OP_LPAR) begin
						if (full) begin
							out_load   = 1'b1;
							out_last_d = 1'b1;
							out_st_d   = ST_OVF;
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + CW'(1);
						end
					end else if (in_code == OP_RPAR) begin
						mode_d  = M_RPAR;
						state_d = S_READ;
					end else begin
						mode_d  = M_OP;
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (mode_q == M_OP && !pop_cond) begin
					if (full) begin
						fin_st_d = ST_OVF;
					end else begin
						ram_we  = 1'b1;
						count_d = count_q + CW'(1);
					end
					state_d = S_FIN;
				end else if (count_q == '0) begin
					fin_st_d = (mode_q == M_RPAR) ? ST_UNM : ST_OK;
					state_d  = S_FIN;
				end else if (top == OP_LPAR) begin
					count_d = count_q - CW'(1);
					state_d = (mode_q == M_RPAR) ? S_FIN : S_READ;
				end else if (emit_ok) begin
					count_d = count_q - CW'(1);
					state_d = S_READ;
					if (nres_q < MAX_RESULTS) begin
						nres_d       = nres_q + RES_W'(1);
						pend_valid_d = 1'b1;
						pend_char_d  = op_char(top);
						if (pend_valid_q) begin
							out_load   = 1'b1;
							out_char_d = pend_char_q;
							out_cv_d   = 1'b1;
						end
					end
				end
			end
			S_FIN: begin
				if (pend_valid_q) begin
					if (out_free) begin
						out_load     = 1'b1;
						out_char_d   = pend_char_q;
						out_cv_d     = 1'b1;
						out_last_d   = 1'b1;
						out_st_d     = fin_st_q;
						pend_valid_d = 1'b0;
						state_d      = S_IDLE;
					end
				end else if (fin_st_q != ST_OK) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_last_d = 1'b1;
						out_st_d   = fin_st_q;
						state_d    = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			pend_valid_q <= pend_valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q      <= mode_d;
		code_q      <= code_d;
		fin_st_q    <= fin_st_d;
		nres_q      <= nres_d;
		pend_char_q <= pend_char_d;
		if (out_load) begin
			out_char_q <= out_char_d;
			out_cv_q   <= out_cv_d;
			out_last_q <= out_last_d;
			out_st_q   <= out_st_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign char_valid  = out_cv_q;
	assign last_of_run = out_last_q;
	assign status      = out_st_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count above depth");

	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("pending item left in idle");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> count_q < DEPTH_C)
		else $error("push onto full stack");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> state_q == S_IDLE)
		else $error("finish step did not return to idle");

endmodule

// ----- dv/itp_checker.sv -----
// ----------------------------------------------------------------------------
// itp_checker
// Watches both channels of the infix to postfix converter, keeps its own
// operator stack to work out the postfix items each input character causes,
// and compares every output item in order against that prediction.
// ----------------------------------------------------------------------------
module itp_checker #(
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  itp_pkg::char_t   in_char,
	input  logic             end_of_expr,
	input  logic             out_valid,
	input  logic             out_stall,
	input  itp_pkg::char_t   out_char,
	input  logic             char_valid,
	input  logic             last_of_run,
	input  itp_pkg::status_t status,
	output int               errors,
	output int               pending,
	output int               n_results,
	output int               n_ovf,
	output int               n_unm
);

	import itp_pkg::*;

	typedef struct packed {
		char_t   ch;
		logic    cv;
		logic    last;
		status_t st;
	} postfix_t;

	postfix_t postfix_q[$];
	postfix_t step_q[$];
	op_code_t op_stack[64];
	int       op_count = 0;

	function automatic op_code_t classify(input char_t c);
		case (c)
			"+":     return OP_ADD;
			"-":     return OP_SUB;
			"*":     return OP_MUL;
			"/":     return OP_DIV;
			"^":     return OP_POW;
			"(":     return OP_LPAR;
			")":     return OP_RPAR;
			default: return OP_NONE;
		endcase
	endfunction

	function automatic char_t glyph(input op_code_t t);
		case (t)
			OP_ADD:  return "+";
			OP_SUB:  return "-";
			OP_MUL:  return "*";
			OP_DIV:  return "/";
			OP_POW:  return "^";
			default: return 8'h00;
		endcase
	endfunction

	function automatic int rank(input op_code_t t);
		case (t)
			OP_ADD, OP_SUB: return 1;
			OP_MUL, OP_DIV: return 2;
			OP_POW:         return 3;
			default:        return 0;
		endcase
	endfunction

	function automatic void emit(input char_t c, input logic cv, input status_t st);
		postfix_t r;
		r = {c, cv, 1'b0, st};
		if (step_q.size() < MAX_RESULTS)
			step_q.push_back(r);
	endfunction

	function automatic void push_op(input op_code_t code);
		if (op_count >= STACK_DEPTH) begin
			emit(8'h00, 1'b0, ST_OVF);
		end else begin
			op_stack[op_count] = code;
			op_count++;
		end
	endfunction

	function automatic void predict_item(input char_t c, input logic eoe);
		op_code_t code;
		op_code_t top;
		logic     done;
		postfix_t tail;
		step_q.delete();
		if (eoe) begin
			while (op_count > 0) begin
				op_count--;
				top = op_stack[op_count];
				if (top != OP_LPAR)
					emit(glyph(top), 1'b1, ST_OK);
			end
		end else begin
			code = classify(c);
			case (code)
				OP_NONE: emit(c, 1'b1, ST_OK);
				OP_LPAR: push_op(code);
				OP_RPAR: begin
					done = 1'b0;
					while (op_count > 0 && !done) begin
						op_count--;
						top = op_stack[op_count];
						if (top == OP_LPAR)
							done = 1'b1;
						else
							emit(glyph(top), 1'b1, ST_OK);
					end
					if (!done) begin
						if (step_q.size() > 0) begin
							tail = step_q.pop_back();
							tail.st = ST_UNM;
							step_q.push_back(tail);
						end else begin
							emit(8'h00, 1'b0, ST_UNM);
						end
					end
				end
				default: begin
					done = 1'b0;
					while (op_count > 0 && !done) begin
						top = op_stack[op_count - 1];
						if (top != OP_LPAR && (rank(top) > rank(code) ||
								(rank(top) == rank(code) && code != OP_POW))) begin
							op_count--;
							emit(glyph(top), 1'b1, ST_OK);
						end else begin
							done = 1'b1;
						end
					end
					push_op(code);
				end
			endcase
		end
		if (step_q.size() > 0) begin
			tail = step_q.pop_back();
			tail.last = 1'b1;
			step_q.push_back(tail);
		end
		foreach (step_q[i])
			postfix_q.push_back(step_q[i]);
	endfunction

	always @(posedge clk) begin
		postfix_t got;
		postfix_t want;
		if (!arst_n) begin
			errors    = 0;
			pending   = 0;
			n_results = 0;
			n_ovf     = 0;
			n_unm     = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {out_char, char_valid, last_of_run, status};
				n_results++;
				if (status == ST_OVF)
					n_ovf++;
				if (status == ST_UNM)
					n_unm++;
				if (postfix_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected item: char %h valid %b last %b status %0d",
							out_char, char_valid, last_of_run, status);
					errors++;
				end else begin
					want = postfix_q.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("mismatch exp/act: char %h/%h valid %b/%b last %b/%b st %0d/%0d",
								want.ch, got.ch, want.cv, got.cv,
								want.last, got.last, want.st, got.st);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_item(in_char, end_of_expr);
			pending = postfix_q.size();
		end
	end

endmodule

// ----- dv/tb_infix_to_postfix_converter.sv -----
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Drives infix characters into the converter: a directed set covering every
// operator, precedence, right associativity of ^, unmatched ')', '(' left at
// the end and the empty flush, then random well-formed expressions, deep
// nesting that overflows the stack, and noise, under three idle/stall mixes.
// The checker beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;
	import itp_pkg::*;

	localparam int STACK_DEPTH = 32;
	localparam int LIMIT       = 400000;
	localparam int PHASE_ITEMS = 85;

	localparam char_t CH_LPAR = "(";
	localparam char_t CH_RPAR = ")";
	localparam char_t CH_POW  = "^";

	logic    clk         = 1'b0;
	logic    arst_n      = 1'b0;
	logic    in_valid    = 1'b0;
	logic    in_stall;
	char_t   in_char     = 8'h00;
	logic    end_of_expr = 1'b0;
	logic    out_valid;
	logic    out_stall   = 1'b0;
	char_t   out_char;
	logic    char_valid;
	logic    last_of_run;
	status_t status;

	int errors;
	int pending;
	int n_results;
	int n_ovf;
	int n_unm;

	int          idle_pct  = 0;
	int          stall_pct = 0;
	int          n_sent    = 0;
	int          n_directed;
	int unsigned cycles    = 0;

	char_t op_syms[5]    = '{"+", "-", "*", "/", "^"};
	char_t noise_syms[7] = '{"+", "-", "*", "/", "^", "(", ")"};

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_char    (in_char),
		.end_of_expr(end_of_expr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.char_valid (char_valid),
		.last_of_run(last_of_run),
		.status     (status)
	);

	itp_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_char    (in_char),
		.end_of_expr(end_of_expr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.char_valid (char_valid),
		.last_of_run(last_of_run),
		.status     (status),
		.errors     (errors),
		.pending    (pending),
		.n_results  (n_results),
		.n_ovf      (n_ovf),
		.n_unm      (n_unm)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb_infix_to_postfix_converter: FAIL");
			$finish;
		end
	end

	task automatic send_item(input char_t c, input logic eoe);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		in_char     <= c;
		end_of_expr <= eoe;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic send_str(input string s);
		foreach (s[i])
			send_item(s[i], 1'b0);
	endtask

	function automatic char_t rand_operand();
		char_t c;
		c = char_t'($urandom);
		while (code_of(c) != OP_NONE)
			c = char_t'($urandom);
		return c;
	endfunction

	// hold the sender and drain every expected item
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic send_expr();
		int terms;
		int nest;
		terms = $urandom_range(1, 6);
		nest  = 0;
		for (int i = 0; i < terms; i++) begin
			if (i > 0)
				send_item(op_syms[$urandom_range(4)], 1'b0);
			while (nest < 6 && $urandom_range(3) == 0) begin
				send_item(CH_LPAR, 1'b0);
				nest++;
			end
			send_item(rand_operand(), 1'b0);
			while (nest > 0 && $urandom_range(2) == 0) begin
				send_item(CH_RPAR, 1'b0);
				nest--;
			end
		end
		while (nest > 0) begin
			send_item(CH_RPAR, 1'b0);
			nest--;
		end
		send_item(char_t'($urandom), 1'b1);
	endtask

	task automatic send_deep(input int lo, input int hi);
		repeat ($urandom_range(hi, lo)) begin
			if ($urandom_range(1))
				send_item(rand_operand(), 1'b0);
			send_item($urandom_range(1) ? CH_LPAR : CH_POW, 1'b0);
		end
		repeat ($urandom_range(3))
			send_item(CH_RPAR, 1'b0);
		send_item(char_t'($urandom), 1'b1);
	endtask

	task automatic send_noise();
		char_t c;
		repeat ($urandom_range(10, 1)) begin
			if ($urandom_range(1))
				c = char_t'($urandom);
			else
				c = noise_syms[$urandom_range(6)];
			send_item(c, $urandom_range(7) == 0);
		end
	endtask

	initial begin
		int target;
		int pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 21;
		stall_pct = 75;
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(CH_RPAR, 1'b0);
		send_item("+", 1'b0);
		send_item(CH_RPAR, 1'b0);
		send_str("a+b*c^d^e/f");
		send_item(8'h00, 1'b1);
		send_str("(a-b)/(");
		send_item(8'hFF, 1'b1);
		n_directed = n_sent;
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct  = (ph == 0) ? 21 : (ph == 1) ? 75 : 0;
			stall_pct = (ph == 0) ? 75 : (ph == 1) ? 21 : 0;
			target    = n_sent + PHASE_ITEMS;
			if (ph == 0)
				send_deep(33, 36);
			else
				send_deep(26, 36);
			while (n_sent < target) begin
				pick = $urandom_range(9);
				if (pick < 7)
					send_expr();
				else
					send_noise();
			end
			drain();
		end

		repeat (100) @(posedge clk);
		@(negedge clk);
		$display("run covered %0d items (%0d directed) and %0d output items checked",
			n_sent, n_directed, n_results);
		$display("overflow statuses %0d, unmatched ')' statuses %0d, mismatches %0d",
			n_ovf, n_unm, errors);
		if (errors == 0 && pending == 0)
			$display("tb_infix_to_postfix_converter: PASS");
		else
			$display("tb_infix_to_postfix_converter: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/itp_pkg.sv
sv/itp_ram.sv
sv/infix_to_postfix_converter.sv
dv/itp_checker.sv
dv/tb_infix_to_postfix_converter.sv
